/* src/tprc_pkg.sv */
// Shared types, codes and arithmetic helpers for the thick-plane ray clip core.
package tprc_pkg;

  // Quotient bits produced by the divider and steps done per divider stage
  localparam int QUO_BITS       = 31;
  localparam int STEPS_PER_ST   = 4;
  localparam int DIV_STAGES     = (QUO_BITS + STEPS_PER_ST - 1) / STEPS_PER_ST;

  // Configuration register indexes
  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_ANCHOR_X = 3'd3;
  localparam logic [2:0] REG_ANCHOR_Y = 3'd4;
  localparam logic [2:0] REG_ANCHOR_Z = 3'd5;
  localparam logic [2:0] REG_HALF_TH  = 3'd6;

  // Hit place codes on the result word
  localparam logic [1:0] PLACE_NONE  = 2'd0;
  localparam logic [1:0] PLACE_START = 2'd1;
  localparam logic [1:0] PLACE_INNER = 2'd2;

  // Outcome of one ray as settled before the divider
  typedef enum logic [1:0] {
    K_MISS   = 2'd0,
    K_INSIDE = 2'd1,
    K_OVF    = 2'd2,
    K_HIT    = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] limit_in;
    logic               unbounded_in;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] limit_out;
    logic               unbounded_out;
    logic [1:0]         hit_place;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic [30:0]        half_th;
  } cfg_t;

  // Front end result: classification and magnitudes of distance and rate
  typedef struct packed {
    logic               in_slab;
    logic               away;
    logic [31:0]        abs_d;
    logic [31:0]        abs_r;
    logic signed [31:0] limit;
    logic               unb;
  } mid_t;

  // Data that rides along the divider untouched
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] limit;
    logic               unb;
  } side_t;

  typedef struct packed {
    logic [31:0]          rem;
    logic [QUO_BITS-1:0]  dq;
  } div_acc_t;

  typedef struct packed {
    div_acc_t    acc;
    logic [31:0] dvs;
    side_t       side;
  } div_word_t;

  // Clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sd2147483647;
    lo = -52'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // One restoring division step: shift in a dividend bit, subtract if it fits
  function automatic div_acc_t div_step(input div_acc_t a, input logic [31:0] dvs);
    logic [32:0] t;
    div_acc_t    n;
    t = {a.rem, a.dq[QUO_BITS-1]};
    if (t >= {1'b0, dvs}) begin
      n.rem = 32'(t - {1'b0, dvs});
      n.dq  = {a.dq[QUO_BITS-2:0], 1'b1};
    end else begin
      n.rem = t[31:0];
      n.dq  = {a.dq[QUO_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

/* src/tprc_front.sv */
// Front end: offset, dot-product multiplies, floor and sum, saturate and classify.
module tprc_front
  import tprc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     up_valid,
  input  in_word_t up_word,
  output logic     up_rdy,
  output logic     dn_valid,
  output mid_t     dn_word,
  input  logic     dn_rdy
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic e1, e2, e3, e4;

  // Stage 1 payload
  logic signed [32:0] dfx_r, dfy_r, dfz_r;
  logic signed [31:0] drx_r, dry_r, drz_r;
  logic signed [31:0] lim1_r;
  logic               unb1_r;

  // Stage 2 payload
  logic signed [64:0] pdx_r, pdy_r, pdz_r;
  logic signed [63:0] prx_r, pry_r, prz_r;
  logic signed [31:0] lim2_r;
  logic               unb2_r;

  // Stage 3 payload
  logic signed [50:0] dsum_r;
  logic signed [49:0] rsum_r;
  logic signed [31:0] lim3_r;
  logic               unb3_r;

  // Stage 4 payload
  mid_t mid_r;

  logic signed [31:0] d_s, r_s;
  logic [32:0]        ad, ar;
  mid_t               mid_nxt;

  // A stage loads when it is empty or its word moves on
  assign e4     = !v4_r || dn_rdy;
  assign e3     = !v3_r || e4;
  assign e2     = !v2_r || e3;
  assign e1     = !v1_r || e2;
  assign up_rdy = e1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (e1) v1_r <= up_valid;
      if (e2) v2_r <= v1_r;
      if (e3) v3_r <= v2_r;
      if (e4) v4_r <= v3_r;
    end
  end

  // Offset origin from anchor
  always_ff @(posedge clk) begin
    if (e1) begin
      dfx_r  <= 33'(up_word.origin_x) - 33'(cfg.anchor_x);
      dfy_r  <= 33'(up_word.origin_y) - 33'(cfg.anchor_y);
      dfz_r  <= 33'(up_word.origin_z) - 33'(cfg.anchor_z);
      drx_r  <= up_word.dir_x;
      dry_r  <= up_word.dir_y;
      drz_r  <= up_word.dir_z;
      lim1_r <= up_word.limit_in;
      unb1_r <= up_word.unbounded_in;
    end
  end

  // Form the six exact products
  always_ff @(posedge clk) begin
    if (e2) begin
      pdx_r  <= 65'(cfg.normal_x) * 65'(dfx_r);
      pdy_r  <= 65'(cfg.normal_y) * 65'(dfy_r);
      pdz_r  <= 65'(cfg.normal_z) * 65'(dfz_r);
      prx_r  <= 64'(cfg.normal_x) * 64'(drx_r);
      pry_r  <= 64'(cfg.normal_y) * 64'(dry_r);
      prz_r  <= 64'(cfg.normal_z) * 64'(drz_r);
      lim2_r <= lim1_r;
      unb2_r <= unb1_r;
    end
  end

  // Floor each product to Q16.16 and sum
  always_ff @(posedge clk) begin
    if (e3) begin
      dsum_r <= 51'($signed(pdx_r[64:16])) + 51'($signed(pdy_r[64:16]))
              + 51'($signed(pdz_r[64:16]));
      rsum_r <= 50'($signed(prx_r[63:16])) + 50'($signed(pry_r[63:16]))
              + 50'($signed(prz_r[63:16]));
      lim3_r <= lim2_r;
      unb3_r <= unb2_r;
    end
  end

  // Saturate distance and rate, then classify
  always_comb begin
    d_s = sat32(52'(dsum_r));
    r_s = sat32(-52'(rsum_r));
    ad  = d_s[31] ? -33'(d_s) : 33'(d_s);
    ar  = r_s[31] ? -33'(r_s) : 33'(r_s);
    mid_nxt.abs_d   = ad[31:0];
    mid_nxt.abs_r   = ar[31:0];
    mid_nxt.in_slab = ad[31:0] < {1'b0, cfg.half_th};
    mid_nxt.away    = (d_s == 32'sd0) || (r_s == 32'sd0) || (d_s[31] != r_s[31]);
    mid_nxt.limit   = lim3_r;
    mid_nxt.unb     = unb3_r;
  end

  always_ff @(posedge clk) begin
    if (e4) mid_r <= mid_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_word  = mid_r;

endmodule

/* src/tprc_div.sv */
// Pipelined restoring divider, a few quotient bits per stage, with sideband.
module tprc_div
  import tprc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  div_word_t up_word,
  output logic      up_rdy,
  output logic      dn_valid,
  output div_word_t dn_word,
  input  logic      dn_rdy
);

  logic      v_r  [DIV_STAGES];
  div_word_t st_r [DIV_STAGES];
  logic      vin  [DIV_STAGES+1];
  div_word_t win  [DIV_STAGES+1];
  logic      rdy  [DIV_STAGES+1];

  assign vin[0]          = up_valid;
  assign win[0]          = up_word;
  assign rdy[DIV_STAGES] = dn_rdy;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    localparam int STEPS = (s == DIV_STAGES - 1) ?
                           QUO_BITS - STEPS_PER_ST * (DIV_STAGES - 1) : STEPS_PER_ST;
    div_acc_t  acc;
    div_word_t res;

    // Run this stage's division steps
    always_comb begin
      acc = win[s].acc;
      for (int k = 0; k < STEPS; k++) begin
        acc = div_step(acc, win[s].dvs);
      end
      res     = win[s];
      res.acc = acc;
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= vin[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) st_r[s] <= res;
    end

    assign vin[s+1] = v_r[s];
    assign win[s+1] = st_r[s];
  end

  assign up_rdy   = rdy[0];
  assign dn_valid = vin[DIV_STAGES];
  assign dn_word  = win[DIV_STAGES];

endmodule

/* src/thick_plane_ray_clip_core.sv */
// Top level: config registers, limit test, divider hookup and output register.
//
// Clips one ray per word against a plane slab set by normal, anchor point and
// half thickness (cfg_we/cfg_index/cfg_wdata, written while the core is idle).
// Input words arrive on in_valid/in_word and leave on out_valid/out_word, one
// result per input, in order. A word is taken when valid is high and stall
// is low.
// A word passes through 4 front-end stages (offset, multiply, floor and sum,
// saturate and classify), 2 stages for the limit product and compare, 8
// divider stages at 4 quotient bits each (3 in the last), and the output
// register. Throughput is one word per cycle while out_stall is low; the
// divider is fully pipelined.
// When out_stall is high the output register holds its word; empty stages
// behind it still fill, so in_stall rises only once every stage holds a word.
// Reset (rst_n low, synchronous) empties the pipeline and loads the plane
// registers with normal (0, 0, 1.0), anchor at the origin and zero thickness.
module thick_plane_ray_clip_core
  import tprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  cfg_t cfg_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_x <= 32'sd0;
      cfg_r.normal_y <= 32'sd0;
      cfg_r.normal_z <= 32'sd65536;
      cfg_r.anchor_x <= 32'sd0;
      cfg_r.anchor_y <= 32'sd0;
      cfg_r.anchor_z <= 32'sd0;
      cfg_r.half_th  <= 31'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_X: cfg_r.normal_x <= cfg_wdata;
        REG_NORMAL_Y: cfg_r.normal_y <= cfg_wdata;
        REG_NORMAL_Z: cfg_r.normal_z <= cfg_wdata;
        REG_ANCHOR_X: cfg_r.anchor_x <= cfg_wdata;
        REG_ANCHOR_Y: cfg_r.anchor_y <= cfg_wdata;
        REG_ANCHOR_Z: cfg_r.anchor_z <= cfg_wdata;
        REG_HALF_TH:  cfg_r.half_th  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic      fe_valid, fe_rdy_up;
  mid_t      fe_word;
  logic      e5, e6, e_out;
  logic      v5_r, v6_r, out_valid_r;
  logic      dv_rdy_up, dv_valid;
  div_word_t dv_word;
  div_word_t w6_r;
  out_word_t out_word_r, out_nxt;

  // Stage 5 payload
  logic               inside5_r, away5_r, unb5_r;
  logic [31:0]        m5_r, absr5_r;
  logic signed [31:0] lim5_r;
  logic signed [64:0] prod5_r;

  logic      take6, ovf6;
  div_word_t w6_nxt;

  tprc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_word  (in_word),
    .up_rdy   (fe_rdy_up),
    .dn_valid (fe_valid),
    .dn_word  (fe_word),
    .dn_rdy   (e5)
  );

  assign in_stall = !fe_rdy_up;

  assign e_out = !out_valid_r || !out_stall;
  assign e6    = !v6_r || dv_rdy_up;
  assign e5    = !v5_r || e6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (e5) v5_r <= fe_valid;
      if (e6) v6_r <= v5_r;
    end
  end

  // Entry numerator magnitude and the limit times rate product
  always_ff @(posedge clk) begin
    if (e5) begin
      inside5_r <= fe_word.in_slab;
      away5_r   <= fe_word.away;
      unb5_r    <= fe_word.unb;
      lim5_r    <= fe_word.limit;
      m5_r      <= fe_word.abs_d - {1'b0, cfg_r.half_th};
      absr5_r   <= fe_word.abs_r;
      prod5_r   <= 65'(fe_word.limit) * $signed({33'd0, fe_word.abs_r});
    end
  end

  // Settle the outcome and seed the divider
  always_comb begin
    take6 = $signed({17'd0, m5_r, 16'd0}) < prod5_r;
    ovf6  = {15'd0, m5_r} >= {absr5_r, 15'd0};
    priority if (inside5_r) begin
      w6_nxt.side.kind = K_INSIDE;
    end else if (away5_r) begin
      w6_nxt.side.kind = K_MISS;
    end else if (!unb5_r && !take6) begin
      w6_nxt.side.kind = K_MISS;
    end else if (unb5_r && ovf6) begin
      w6_nxt.side.kind = K_OVF;
    end else begin
      w6_nxt.side.kind = K_HIT;
    end
    w6_nxt.side.limit = lim5_r;
    w6_nxt.side.unb   = unb5_r;
    w6_nxt.acc.rem    = {15'd0, m5_r[31:15]};
    w6_nxt.acc.dq     = {m5_r[14:0], 16'd0};
    w6_nxt.dvs        = absr5_r;
  end

  always_ff @(posedge clk) begin
    if (e6) w6_r <= w6_nxt;
  end

  tprc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v6_r),
    .up_word  (w6_r),
    .up_rdy   (dv_rdy_up),
    .dn_valid (dv_valid),
    .dn_word  (dv_word),
    .dn_rdy   (e_out)
  );

  // Build the result word
  always_comb begin
    unique case (dv_word.side.kind)
      K_INSIDE: begin
        out_nxt.hit           = 1'b1;
        out_nxt.limit_out     = 32'sd0;
        out_nxt.unbounded_out = 1'b0;
        out_nxt.hit_place     = PLACE_START;
      end
      K_OVF: begin
        out_nxt.hit           = 1'b0;
        out_nxt.limit_out     = 32'sd0;
        out_nxt.unbounded_out = 1'b1;
        out_nxt.hit_place     = PLACE_NONE;
      end
      K_HIT: begin
        out_nxt.hit           = 1'b1;
        out_nxt.limit_out     = {1'b0, dv_word.acc.dq};
        out_nxt.unbounded_out = 1'b0;
        out_nxt.hit_place     = PLACE_INNER;
      end
      default: begin
        out_nxt.hit           = 1'b0;
        out_nxt.limit_out     = dv_word.side.limit;
        out_nxt.unbounded_out = dv_word.side.unb;
        out_nxt.hit_place     = PLACE_NONE;
      end
    endcase
  end

  // Hold the output word while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_out) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_out) out_word_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A hit always names where it happened
  a_hit_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.hit |-> out_word_r.hit_place != PLACE_NONE)
    else $error("hit without hit place");

  // A start-point hit clears the limit and the unbounded flag
  a_start_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.hit_place == PLACE_START |->
      out_word_r.limit_out == 32'sd0 && !out_word_r.unbounded_out)
    else $error("start hit with nonzero limit");

  // A quotient hit never carries a negative limit
  a_hit_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.hit_place == PLACE_INNER |-> !out_word_r.limit_out[31])
    else $error("negative entry parameter");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the thick-plane ray clip core.
`timescale 1ns / 100ps

module tb_top;
  import tprc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  thick_plane_ray_clip_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // Plane copy held by the predictor
  longint pl_n[3];
  longint pl_a[3];
  longint pl_h;

  out_word_t clip_queue[$];
  int        n_checked = 0;
  int        n_bad = 0;
  int        n_hits = 0;
  int        n_sent = 0;
  int        out_wait = 0;
  bit        rand_out_stall = 1'b0;

  function automatic longint floor16(longint v);
    longint q;
    q = v / 65536;
    if (v < 0 && (v % 65536) != 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Predict the clip result of one ray against the current plane
  function automatic out_word_t clip_ray(in_word_t w);
    out_word_t o;
    longint o3[3];
    longint d3[3];
    longint d, r, num, q, lim;
    o3[0] = w.origin_x; o3[1] = w.origin_y; o3[2] = w.origin_z;
    d3[0] = w.dir_x; d3[1] = w.dir_y; d3[2] = w.dir_z;
    lim = w.limit_in;
    o.hit = 1'b0;
    o.limit_out = w.limit_in;
    o.unbounded_out = w.unbounded_in;
    o.hit_place = PLACE_NONE;
    d = 0;
    r = 0;
    for (int i = 0; i < 3; i++) begin
      d += floor16(pl_n[i] * (o3[i] - pl_a[i]));
      r += floor16(pl_n[i] * d3[i]);
    end
    d = clamp32(d);
    r = clamp32(-r);
    if (d > -pl_h && d < pl_h) begin
      o.hit = 1'b1; o.limit_out = '0; o.unbounded_out = 1'b0;
      o.hit_place = PLACE_START;
      return o;
    end
    if (r == 0 || d == 0 || ((r > 0) != (d > 0))) return o;
    num = (r > 0) ? (d - pl_h) * 65536 : (d + pl_h) * 65536;
    if (!w.unbounded_in) begin
      if ((r > 0) ? !(num < lim * r) : !(num > lim * r)) return o;
      q = num / r;
    end else begin
      q = num / r;
      if (q > 64'sd2147483647) begin
        o.limit_out = '0;
        return o;
      end
    end
    o.hit = 1'b1;
    o.limit_out = q[31:0];
    o.unbounded_out = 1'b0;
    o.hit_place = PLACE_INNER;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NORMAL_X: pl_n[0] = longint'($signed(val));
      REG_NORMAL_Y: pl_n[1] = longint'($signed(val));
      REG_NORMAL_Z: pl_n[2] = longint'($signed(val));
      REG_ANCHOR_X: pl_a[0] = longint'($signed(val));
      REG_ANCHOR_Y: pl_a[1] = longint'($signed(val));
      REG_ANCHOR_Z: pl_a[2] = longint'($signed(val));
      REG_HALF_TH:  pl_h = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic load_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                            logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                            logic [31:0] ht);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_ANCHOR_X, ax);
    write_reg(REG_ANCHOR_Y, ay);
    write_reg(REG_ANCHOR_Z, az);
    write_reg(REG_HALF_TH, ht);
  endtask

  // Send one ray word, hold it until taken, then queue its expected result.
  // Called at a falling edge; valid stays up after the take so a word with
  // no gap follows directly.
  task automatic send_ray(in_word_t w, bit has_exp, out_word_t exp_w);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_queue.push_back(has_exp ? exp_w : clip_ray(w));
    n_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for all expected words, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_q16();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  function automatic in_word_t rnd_ray();
    in_word_t w;
    w.origin_x = rnd_q16(); w.origin_y = rnd_q16(); w.origin_z = rnd_q16();
    w.dir_x = rnd_q16(); w.dir_y = rnd_q16(); w.dir_z = rnd_q16();
    w.limit_in = $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 1 << 24);
    w.unbounded_in = $urandom_range(0, 1);
    return w;
  endfunction

  // Receiver: hold off each word for its drawn number of cycles
  always @(negedge clk) begin
    if (rand_out_stall && out_valid && out_wait > 0) begin
      out_stall <= 1'b1;
      out_wait <= out_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted word and draw the wait for the next one
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      out_wait <= rand_out_stall ? $urandom_range(0, 6) : 0;
      if (clip_queue.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_w = clip_queue.pop_front();
        n_checked++;
        if (out_word.hit) n_hits++;
        if (out_word.hit !== exp_w.hit || out_word.limit_out !== exp_w.limit_out ||
            out_word.unbounded_out !== exp_w.unbounded_out ||
            out_word.hit_place !== exp_w.hit_place) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch #%0d: exp hit=%b lim=%h unb=%b pl=%0d got hit=%b lim=%h unb=%b pl=%0d",
                     n_checked, exp_w.hit, exp_w.limit_out, exp_w.unbounded_out,
                     exp_w.hit_place, out_word.hit, out_word.limit_out,
                     out_word.unbounded_out, out_word.hit_place);
        end
      end
    end
  end

  // Directed rays: origin, direction, limit, unbounded, known result or not
  typedef struct {
    in_word_t  w;
    bit        has_exp;
    out_word_t exp_w;
  } ray_row_t;

  localparam logic [31:0] ONE = 32'h00010000;
  localparam logic [31:0] M_ONE = 32'hffff0000;

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    ray_row_t rows[$];
    ray_row_t rw;
    out_word_t none_w;
    none_w = '0;
    pl_n[0] = 0; pl_n[1] = 0; pl_n[2] = 65536;
    pl_a[0] = 0; pl_a[1] = 0; pl_a[2] = 0;
    pl_h = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset: plane z=0, zero thickness
    // Origin on plane: d=0 -> miss, unchanged
    rw.w = '{0, 0, 0, 0, 0, M_ONE, 32'h1234, 1'b0};
    rw.has_exp = 1; rw.exp_w = '{1'b0, 32'h1234, 1'b0, PLACE_NONE}; rows.push_back(rw);
    // Above plane moving down, unbounded: t = 2.0
    rw.w = '{0, 0, 2 * ONE, 0, 0, M_ONE, 0, 1'b1};
    rw.has_exp = 1; rw.exp_w = '{1'b1, 2 * ONE, 1'b0, PLACE_INNER}; rows.push_back(rw);
    // Moving away
    rw.w = '{0, 0, 2 * ONE, 0, 0, ONE, 32'h55, 1'b1};
    rw.has_exp = 1; rw.exp_w = '{1'b0, 32'h55, 1'b1, PLACE_NONE}; rows.push_back(rw);
    // Parallel
    rw.w = '{0, 0, 2 * ONE, ONE, 0, 0, 32'h77, 1'b0};
    rw.has_exp = 1; rw.exp_w = '{1'b0, 32'h77, 1'b0, PLACE_NONE}; rows.push_back(rw);
    // Bounded, beyond limit (t=2 vs limit 1)
    rw.w = '{0, 0, 2 * ONE, 0, 0, M_ONE, ONE, 1'b0};
    rw.has_exp = 1; rw.exp_w = '{1'b0, ONE, 1'b0, PLACE_NONE}; rows.push_back(rw);
    // Bounded, within limit
    rw.w = '{0, 0, 2 * ONE, 0, 0, M_ONE, 3 * ONE, 1'b0};
    rw.has_exp = 1; rw.exp_w = '{1'b1, 2 * ONE, 1'b0, PLACE_INNER}; rows.push_back(rw);
    // Below plane moving up
    rw.w = '{0, 0, M_ONE, 0, 0, ONE, 0, 1'b1};
    rw.has_exp = 1; rw.exp_w = '{1'b1, ONE, 1'b0, PLACE_INNER}; rows.push_back(rw);
    // Quotient overflow on an unbounded ray
    rw.w = '{0, 0, 32'h7fffffff, 0, 0, 32'hffffffff, 0, 1'b1};
    rw.has_exp = 1; rw.exp_w = '{1'b0, 32'h0, 1'b1, PLACE_NONE}; rows.push_back(rw);
    // Extremes, predicted
    rw.has_exp = 0; rw.exp_w = none_w;
    rw.w = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h80000000, 1'b0}; rows.push_back(rw);
    rw.w = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h7fffffff, 1'b1}; rows.push_back(rw);
    rw.w = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
             32'hffffffff, 32'hffffffff, 1'b1}; rows.push_back(rw);
    rw.w = '{0, 0, 32'h80000000, 0, 0, 32'h7fffffff, 32'h80000000, 1'b0}; rows.push_back(rw);
    rw.w = '{0, 0, 5 * ONE, 0, 0, M_ONE, 32'h80000000, 1'b0}; rows.push_back(rw);

    rand_out_stall = 1'b1;
    foreach (rows[i]) send_ray(rows[i].w, rows[i].has_exp, rows[i].exp_w);
    drain();

    // Thick slab: inside start, entry on each face
    load_plane(0, 0, ONE, 0, 0, ONE, ONE);
    send_ray('{0, 0, ONE + 32'h100, 0, 0, 0, 32'h99, 1'b1}, 1,
             '{1'b1, 32'h0, 1'b0, PLACE_START});
    send_ray('{0, 0, 4 * ONE, 0, 0, M_ONE, 0, 1'b1}, 1,
             '{1'b1, 2 * ONE, 1'b0, PLACE_INNER});
    send_ray('{0, 0, 32'hfffc0000, 0, 0, ONE, 0, 1'b1}, 1,
             '{1'b1, 4 * ONE, 1'b0, PLACE_INNER});
    send_ray('{0, 0, 2 * ONE, 0, 0, M_ONE, 4 * ONE, 1'b0}, 0, none_w);
    drain();

    // Extreme plane settings
    load_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < 8; i++) send_ray(rnd_ray(), 0, none_w);
    drain();
    load_plane(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h0);
    for (int i = 0; i < 8; i++) send_ray(rnd_ray(), 0, none_w);
    drain();

    // Random phases, each with a fresh plane; some phases run without stalls
    for (int ph = 0; ph < 10; ph++) begin
      rand_out_stall = (ph % 3 != 0);
      if (ph % 2 == 0)
        load_plane(rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16(), rnd_q16(),
                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4 * ONE));
      else
        load_plane($urandom_range(0, 1) ? ONE : M_ONE,
                   32'($signed($urandom_range(0, ONE)) - (ONE / 2)),
                   32'($signed($urandom_range(0, ONE)) - (ONE / 2)),
                   rnd_q16(), rnd_q16(), rnd_q16(), $urandom_range(0, 8 * ONE));
      for (int i = 0; i < 82; i++) send_ray(rnd_ray(), 0, none_w);
      drain();
    end

    $display("rays sent %0d, results checked %0d, hits %0d", n_sent, n_checked, n_hits);
    $display("covered slab inside, entry on both faces, misses, limits and overflow");
    if (n_bad == 0 && clip_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
src/tprc_pkg.sv
src/tprc_front.sv
src/tprc_div.sv
src/thick_plane_ray_clip_core.sv
tb/sv/tb_top.sv
